FILE: rtl/core/dmrhd_pkg.sv
package dmrhd_pkg;

    // Field widths
    localparam int SPEED_W     = 9;
    localparam int TARGET_W    = 16;
    localparam int STEP_W      = 8;
    localparam int TICK_W      = 16;
    localparam int PWM_BITS_W  = 4;
    localparam int DUTY_W      = 14;
    localparam int MAG_W       = 8;
    localparam int PROD_W      = 22;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 56;

    localparam int SPEED_LIMIT  = 255;
    localparam logic [PWM_BITS_W-1:0] PWM_BITS_MAX = 4'd14;
    localparam logic [TICK_W-1:0]     TICK_SAT     = 16'hFFFF;

    // Reset values of the registers
    localparam logic [STEP_W-1:0]     RAMP_STEP_RST     = 8'd5;
    localparam logic [TICK_W-1:0]     RAMP_INTERVAL_RST = 16'd10;
    localparam logic [PWM_BITS_W-1:0] PWM_BITS_RST      = 4'd8;

    // Result beat layout, lowest bit up
    localparam int M_L_IN1   = 0;
    localparam int M_L_IN2   = 1;
    localparam int M_L_DUTY  = 2;
    localparam int M_R_IN1   = 16;
    localparam int M_R_IN2   = 17;
    localparam int M_R_DUTY  = 18;
    localparam int M_STBY    = 32;
    localparam int M_L_SPEED = 33;
    localparam int M_R_SPEED = 42;

    typedef enum logic [S_TUSER_W-1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_SET_TARGET = 2'd1,
        FUNC_STANDBY    = 2'd2,
        FUNC_STOP       = 2'd3
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_RAMP_STEP     = 3'd0,
        CFG_RAMP_INTERVAL = 3'd1,
        CFG_INVERT_LEFT   = 3'd2,
        CFG_INVERT_RIGHT  = 3'd3,
        CFG_PWM_BITS      = 3'd4
    } cfg_addr_t;

    // Clamp a raw target to +-SPEED_LIMIT
    function automatic logic signed [SPEED_W-1:0] clamp_target(
        input logic signed [TARGET_W-1:0] v
    );
        logic signed [SPEED_W-1:0] res;
        if (v > TARGET_W'(SPEED_LIMIT)) begin
            res = SPEED_W'(SPEED_LIMIT);
        end else if (v < -TARGET_W'(SPEED_LIMIT)) begin
            res = -SPEED_W'(SPEED_LIMIT);
        end else begin
            res = v[SPEED_W-1:0];
        end
        return res;
    endfunction

    // Move cur toward goal by at most step
    function automatic logic signed [SPEED_W-1:0] ramp_toward(
        input logic signed [SPEED_W-1:0] cur,
        input logic signed [SPEED_W-1:0] goal,
        input logic [STEP_W-1:0]         step
    );
        logic signed [SPEED_W+1:0] up;
        logic signed [SPEED_W+1:0] dn;
        logic signed [SPEED_W+1:0] goal_x;
        logic signed [SPEED_W-1:0] res;
        goal_x = (SPEED_W+2)'(goal);
        up     = (SPEED_W+2)'(cur) + $signed({2'b00, step});
        dn     = (SPEED_W+2)'(cur) - $signed({2'b00, step});
        if (goal > cur) begin
            res = (up < goal_x) ? up[SPEED_W-1:0] : goal;
        end else if (goal < cur) begin
            res = (dn > goal_x) ? dn[SPEED_W-1:0] : goal;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    // Floor of x / 255: shift-add estimate (never high, at most one low)
    // followed by one remainder check
    function automatic logic [DUTY_W-1:0] div_limit(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] est_sum;
        logic [DUTY_W-1:0] q;
        logic [PROD_W-1:0] rem;
        est_sum = x + (x >> 8) + (x >> 16);
        q       = est_sum[PROD_W-1:8];
        rem     = x - (PROD_W'(q) << 8) + PROD_W'(q);
        if (rem >= PROD_W'(SPEED_LIMIT)) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

endpackage

FILE: rtl/core/dual_motor_ramp_hbridge_drive.sv
// Throughput: one beat per cycle while the result side takes beats; three register stages
// (state update, duty product, divide by 255 into the output register), each stage holds
// while its successor is full and stalled.
// Reset (aresetn low, synchronous): registers back to defaults, speeds and goals zero,
// standby on, tick counter zero, all stages emptied.
module dual_motor_ramp_hbridge_drive (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [dmrhd_pkg::CFG_ADDR_W-1:0]   cfg_wr_addr,
    input  logic [dmrhd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // command beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // left_target[15:0], right_target[31:16], standby_request[32], zero pad
    input  logic [dmrhd_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [dmrhd_pkg::S_TUSER_W-1:0]    s_tuser,
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left_in1[0], left_in2[1], left_duty[15:2], right_in1[16], right_in2[17],
    // right_duty[31:18], standby_pin_level[32], left_speed_now[41:33],
    // right_speed_now[50:42], zero pad
    output logic [dmrhd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import dmrhd_pkg::*;

    // configuration registers
    logic [STEP_W-1:0]     step_size_reg;
    logic [TICK_W-1:0]     ramp_interval_reg;
    logic                  invert_left_reg;
    logic                  invert_right_reg;
    logic [PWM_BITS_W-1:0] pwm_bits_reg;

    // motion state
    logic signed [SPEED_W-1:0] left_speed_reg, left_speed_next;
    logic signed [SPEED_W-1:0] right_speed_reg, right_speed_next;
    logic signed [SPEED_W-1:0] left_goal_reg, left_goal_next;
    logic signed [SPEED_W-1:0] right_goal_reg, right_goal_next;
    logic                      standby_reg, standby_next;
    logic [TICK_W-1:0]         elapsed_reg, elapsed_next;

    // pipeline
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic s_accept;

    logic signed [SPEED_W-1:0] l_spd1_reg, r_spd1_reg;
    logic                      stby1_reg;

    logic signed [SPEED_W-1:0] l_spd2_reg, r_spd2_reg;
    logic                      stby2_reg;
    logic                      l_in1_2_reg, l_in2_2_reg, r_in1_2_reg, r_in2_2_reg;
    logic [PROD_W-1:0]         l_prod2_reg, r_prod2_reg;

    logic signed [SPEED_W-1:0] l_spd3_reg, r_spd3_reg;
    logic                      stby3_reg;
    logic                      l_in1_3_reg, l_in2_3_reg, r_in1_3_reg, r_in2_3_reg;
    logic [DUTY_W-1:0]         l_duty3_reg, r_duty3_reg;

    // stage 2 drive terms
    logic signed [SPEED_W-1:0] l_drv, r_drv;
    logic [MAG_W-1:0]          l_mag, r_mag;
    logic [PWM_BITS_W-1:0]     bits_eff;
    logic [PROD_W-1:0]         l_prod, r_prod;

    // input fields
    func_t                     in_func;
    logic signed [TARGET_W-1:0] in_left_target, in_right_target;
    logic                      in_standby_req;
    logic [TICK_W-1:0]         elapsed_inc;
    logic                      ramp_now;

    assign in_func         = func_t'(s_tuser);
    assign in_left_target  = $signed(s_tdata[15:0]);
    assign in_right_target = $signed(s_tdata[31:16]);
    assign in_standby_req  = s_tdata[32];

    // stage ready chain: a stage takes a beat when empty or draining
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign s_accept = s_tvalid && rdy1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg     <= RAMP_STEP_RST;
            ramp_interval_reg <= RAMP_INTERVAL_RST;
            invert_left_reg   <= 1'b0;
            invert_right_reg  <= 1'b0;
            pwm_bits_reg      <= PWM_BITS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr_t'(cfg_wr_addr))
                CFG_RAMP_STEP:     step_size_reg     <= cfg_wr_data[STEP_W-1:0];
                CFG_RAMP_INTERVAL: ramp_interval_reg <= cfg_wr_data[TICK_W-1:0];
                CFG_INVERT_LEFT:   invert_left_reg   <= cfg_wr_data[0];
                CFG_INVERT_RIGHT:  invert_right_reg  <= cfg_wr_data[0];
                CFG_PWM_BITS:      pwm_bits_reg      <= cfg_wr_data[PWM_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // command decode and ramp step
    assign elapsed_inc = (elapsed_reg != TICK_SAT) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign ramp_now    = !standby_reg && (elapsed_inc >= ramp_interval_reg);

    always_comb begin
        left_speed_next  = left_speed_reg;
        right_speed_next = right_speed_reg;
        left_goal_next   = left_goal_reg;
        right_goal_next  = right_goal_reg;
        standby_next     = standby_reg;
        elapsed_next     = elapsed_reg;
        unique case (in_func)
            FUNC_TICK: begin
                elapsed_next = elapsed_inc;
                if (ramp_now) begin
                    elapsed_next     = '0;
                    left_speed_next  = ramp_toward(left_speed_reg, left_goal_reg,
                                                   step_size_reg);
                    right_speed_next = ramp_toward(right_speed_reg, right_goal_reg,
                                                   step_size_reg);
                end
            end
            FUNC_SET_TARGET: begin
                left_goal_next  = clamp_target(in_left_target);
                right_goal_next = clamp_target(in_right_target);
            end
            FUNC_STANDBY: begin
                standby_next = in_standby_req;
                if (in_standby_req) begin
                    left_speed_next  = '0;
                    right_speed_next = '0;
                    left_goal_next   = '0;
                    right_goal_next  = '0;
                end
            end
            FUNC_STOP: begin
                left_speed_next  = '0;
                right_speed_next = '0;
                left_goal_next   = '0;
                right_goal_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
            left_goal_reg   <= '0;
            right_goal_reg  <= '0;
            standby_reg     <= 1'b1;
            elapsed_reg     <= '0;
        end else if (s_accept) begin
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
            left_goal_reg   <= left_goal_next;
            right_goal_reg  <= right_goal_next;
            standby_reg     <= standby_next;
            elapsed_reg     <= elapsed_next;
        end
    end

    // stage 2: inversion, direction pins, magnitude times full scale
    assign bits_eff = (pwm_bits_reg > PWM_BITS_MAX) ? PWM_BITS_MAX : pwm_bits_reg;
    assign l_drv    = invert_left_reg  ? -l_spd1_reg : l_spd1_reg;
    assign r_drv    = invert_right_reg ? -r_spd1_reg : r_spd1_reg;
    assign l_mag    = l_drv[SPEED_W-1] ? MAG_W'(-l_drv) : l_drv[MAG_W-1:0];
    assign r_mag    = r_drv[SPEED_W-1] ? MAG_W'(-r_drv) : r_drv[MAG_W-1:0];
    // mag * (2^bits - 1) as a shift and subtract
    assign l_prod   = (PROD_W'(l_mag) << bits_eff) - PROD_W'(l_mag);
    assign r_prod   = (PROD_W'(r_mag) << bits_eff) - PROD_W'(r_mag);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            l_spd1_reg <= left_speed_next;
            r_spd1_reg <= right_speed_next;
            stby1_reg  <= standby_next;
        end
        if (v1_reg && rdy2) begin
            l_spd2_reg  <= l_spd1_reg;
            r_spd2_reg  <= r_spd1_reg;
            stby2_reg   <= stby1_reg;
            l_in1_2_reg <= !l_drv[SPEED_W-1] && (l_drv != '0);
            l_in2_2_reg <= l_drv[SPEED_W-1];
            r_in1_2_reg <= !r_drv[SPEED_W-1] && (r_drv != '0);
            r_in2_2_reg <= r_drv[SPEED_W-1];
            l_prod2_reg <= l_prod;
            r_prod2_reg <= r_prod;
        end
        if (v2_reg && rdy3) begin
            l_spd3_reg  <= l_spd2_reg;
            r_spd3_reg  <= r_spd2_reg;
            stby3_reg   <= stby2_reg;
            l_in1_3_reg <= l_in1_2_reg;
            l_in2_3_reg <= l_in2_2_reg;
            r_in1_3_reg <= r_in1_2_reg;
            r_in2_3_reg <= r_in2_2_reg;
            l_duty3_reg <= div_limit(l_prod2_reg);
            r_duty3_reg <= div_limit(r_prod2_reg);
        end
    end

    // result beat
    assign m_tvalid = v3_reg;
    assign m_tdata  = {5'b00000, r_spd3_reg, l_spd3_reg, !stby3_reg,
                       r_duty3_reg, r_in2_3_reg, r_in1_3_reg,
                       l_duty3_reg, l_in2_3_reg, l_in1_3_reg};

endmodule

FILE: rtl/core/dmrhd_checker.sv
module dmrhd_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [dmrhd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dmrhd_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // bridge inputs never both high
    a_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_L_IN1] && m_tdata[M_L_IN2]) &&
                     !(m_tdata[M_R_IN1] && m_tdata[M_R_IN2]))
        else $error("bridge shoot-through pin pattern");

    // no left direction means no left duty
    a_idle_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_L_IN1] && !m_tdata[M_L_IN2] |->
            m_tdata[M_L_DUTY +: DUTY_W] == '0)
        else $error("left duty without direction");

    // in standby both speeds are zero
    a_standby: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_STBY] |->
            m_tdata[M_L_SPEED +: SPEED_W] == '0 && m_tdata[M_R_SPEED +: SPEED_W] == '0)
        else $error("motion while in standby");

    // speeds stay within the limit
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_L_SPEED +: SPEED_W] != 9'h100 &&
                     m_tdata[M_R_SPEED +: SPEED_W] != 9'h100)
        else $error("speed beyond limit");

endmodule

bind dual_motor_ramp_hbridge_drive dmrhd_checker u_dmrhd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/dual_motor_ramp_hbridge_drive_tb.sv
`timescale 1ns / 1ps

import dmrhd_pkg::*;

// One result beat as the bridge should see it
typedef struct {
    logic                      l_in1;
    logic                      l_in2;
    logic [DUTY_W-1:0]         l_duty;
    logic                      r_in1;
    logic                      r_in2;
    logic [DUTY_W-1:0]         r_duty;
    logic                      stby_pin;
    logic signed [SPEED_W-1:0] l_speed;
    logic signed [SPEED_W-1:0] r_speed;
} bridge_beat_t;

// Ramp and bridge predictor plus the queue of bridge beats still owed by the block
class ramp_drive_book;
    logic [STEP_W-1:0]     step_size;
    logic [TICK_W-1:0]     ramp_interval;
    logic                  inv_left;
    logic                  inv_right;
    logic [PWM_BITS_W-1:0] pwm_res;

    int          left_speed;
    int          right_speed;
    int          left_goal;
    int          right_goal;
    bit          in_standby;
    int unsigned elapsed;

    bridge_beat_t bridge_due[$];

    int errors;
    int beats_checked;
    int ramp_moves;
    int standby_entries;
    int stops;
    int sat_ticks;
    int reg_writes;

    function new();
        step_size       = RAMP_STEP_RST;
        ramp_interval   = RAMP_INTERVAL_RST;
        inv_left        = 1'b0;
        inv_right       = 1'b0;
        pwm_res         = PWM_BITS_RST;
        in_standby      = 1'b1;
        elapsed         = 0;
        errors          = 0;
        beats_checked   = 0;
        ramp_moves      = 0;
        standby_entries = 0;
        stops           = 0;
        sat_ticks       = 0;
        reg_writes      = 0;
        zero_motion();
    endfunction

    function void write_reg(cfg_addr_t addr, logic [CFG_DATA_W-1:0] data);
        reg_writes++;
        case (addr)
            CFG_RAMP_STEP:     step_size     = data[STEP_W-1:0];
            CFG_RAMP_INTERVAL: ramp_interval = data[TICK_W-1:0];
            CFG_INVERT_LEFT:   inv_left      = data[0];
            CFG_INVERT_RIGHT:  inv_right     = data[0];
            CFG_PWM_BITS:      pwm_res       = data[PWM_BITS_W-1:0];
            default: ;
        endcase
    endfunction

    function void zero_motion();
        left_speed  = 0;
        right_speed = 0;
        left_goal   = 0;
        right_goal  = 0;
    endfunction

    function int clamp(int v);
        if (v > SPEED_LIMIT) return SPEED_LIMIT;
        if (v < -SPEED_LIMIT) return -SPEED_LIMIT;
        return v;
    endfunction

    // Move cur toward goal by at most one step
    function int slew(int cur, int goal);
        int s;
        s = int'(step_size);
        if (goal > cur) return (cur + s < goal) ? cur + s : goal;
        if (goal < cur) return (cur - s > goal) ? cur - s : goal;
        return cur;
    endfunction

    // Direction pins and scaled duty for one channel
    function void drive(int speed, logic inv, output logic in1, output logic in2,
                        output logic [DUTY_W-1:0] duty);
        int          s;
        int unsigned bits;
        int unsigned full;
        int unsigned mag;
        s    = clamp(inv ? -speed : speed);
        bits = (pwm_res > PWM_BITS_MAX) ? PWM_BITS_MAX : pwm_res;
        full = (1 << bits) - 1;
        mag  = (s < 0) ? -s : s;
        in1  = (s > 0);
        in2  = (s < 0);
        duty = DUTY_W'(mag * full / SPEED_LIMIT);
    endfunction

    // Apply one accepted command beat and queue the bridge beat it must produce
    function void note_command(func_t f, logic [TARGET_W-1:0] lt, logic [TARGET_W-1:0] rt,
                               logic sb);
        bridge_beat_t e;
        int           nl;
        int           nr;
        case (f)
            FUNC_TICK: begin
                if (elapsed < TICK_SAT) elapsed++;
                else sat_ticks++;
                if (!in_standby && elapsed >= ramp_interval) begin
                    elapsed = 0;
                    nl = slew(left_speed, left_goal);
                    nr = slew(right_speed, right_goal);
                    if (nl != left_speed || nr != right_speed) ramp_moves++;
                    left_speed  = nl;
                    right_speed = nr;
                end
            end
            FUNC_SET_TARGET: begin
                left_goal  = clamp(int'($signed(lt)));
                right_goal = clamp(int'($signed(rt)));
            end
            FUNC_STANDBY: begin
                in_standby = sb;
                if (sb) begin
                    standby_entries++;
                    zero_motion();
                end
            end
            FUNC_STOP: begin
                stops++;
                zero_motion();
            end
        endcase
        drive(left_speed, inv_left, e.l_in1, e.l_in2, e.l_duty);
        drive(right_speed, inv_right, e.r_in1, e.r_in2, e.r_duty);
        e.stby_pin = !in_standby;
        e.l_speed  = SPEED_W'(left_speed);
        e.r_speed  = SPEED_W'(right_speed);
        bridge_due.push_back(e);
    endfunction

    function void cmp(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endfunction

    // Compare one result beat with the oldest owed bridge beat
    function void check_beat(logic [M_TDATA_W-1:0] d);
        bridge_beat_t e;
        if (bridge_due.size() == 0) begin
            $error("result beat %h arrived with no command outstanding", d);
            errors++;
            return;
        end
        e = bridge_due.pop_front();
        beats_checked++;
        cmp("left_in1", e.l_in1, d[M_L_IN1]);
        cmp("left_in2", e.l_in2, d[M_L_IN2]);
        cmp("left_duty", e.l_duty, d[M_L_DUTY +: DUTY_W]);
        cmp("right_in1", e.r_in1, d[M_R_IN1]);
        cmp("right_in2", e.r_in2, d[M_R_IN2]);
        cmp("right_duty", e.r_duty, d[M_R_DUTY +: DUTY_W]);
        cmp("standby_pin_level", e.stby_pin, d[M_STBY]);
        cmp("left_speed_now", e.l_speed, $signed(d[M_L_SPEED +: SPEED_W]));
        cmp("right_speed_now", e.r_speed, $signed(d[M_R_SPEED +: SPEED_W]));
    endfunction

    function int pending();
        return bridge_due.size();
    endfunction
endclass

module dual_motor_ramp_hbridge_drive_tb;
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int STBY_TICK_RUN = 40;
    localparam int EDGE_TARGETS [6] = '{255, -255, 256, -256, 32767, -32768};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_wr_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int send_idle_pct = 16;
    int recv_idle_pct = 87;
    int cycles = 0;

    ramp_drive_book book;

    dual_motor_ramp_hbridge_drive dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles, book.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random back-pressure, check every accepted beat
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready) book.check_beat(m_tdata);
    end

    // Present one command beat, with random gaps ahead of it, and wait for the handshake
    task automatic send_cmd(func_t f, int lt, int rt, logic sb);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = S_TDATA_W'({sb, 16'(rt), 16'(lt)});
        do @(posedge aclk); while (!s_tready);
        book.note_command(f, 16'(lt), 16'(rt), sb);
    endtask

    // Stop sending and wait until every owed beat has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(cfg_addr_t addr, int value);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_addr = addr;
        cfg_wr_data = CFG_DATA_W'(value);
        @(posedge aclk);
        book.write_reg(addr, CFG_DATA_W'(value));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(int step, int interval, bit inv_l, bit inv_r, int res);
        set_reg(CFG_RAMP_STEP, step);
        set_reg(CFG_RAMP_INTERVAL, interval);
        set_reg(CFG_INVERT_LEFT, inv_l);
        set_reg(CFG_INVERT_RIGHT, inv_r);
        set_reg(CFG_PWM_BITS, res);
    endtask

    // Mostly moderate speeds, some clamp edges, some raw 16-bit values
    function automatic int pick_target();
        case ($urandom_range(9))
            0:       return int'($signed(16'($urandom())));
            1:       return EDGE_TARGETS[$urandom_range(5)];
            default: return $urandom_range(600) - 300;
        endcase
    endfunction

    // Ticks dominate so the ramp gets to run; unused fields carry noise
    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 68) begin
            send_cmd(FUNC_TICK, $urandom(), $urandom(), 1'($urandom()));
        end else if (r < 83) begin
            send_cmd(FUNC_SET_TARGET, pick_target(), pick_target(), 1'($urandom()));
        end else if (r < 92) begin
            send_cmd(FUNC_STANDBY, $urandom(), $urandom(), $urandom_range(99) < 25);
        end else begin
            send_cmd(FUNC_STOP, $urandom(), $urandom(), 1'($urandom()));
        end
    endtask

    initial begin
        book        = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_addr = CFG_RAMP_STEP;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tuser     = FUNC_TICK;
        s_tdata     = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset defaults: standby on, interval ten, eight-bit duty
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, 50, -50, 1'b0);
        send_cmd(FUNC_STANDBY, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        drain();

        // Full step, ramp on every tick, left inverted, widest duty
        configure(255, 0, 1'b1, 1'b0, 14);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, 32767, -32768, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, 256, -256, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, -255, 255, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, -1, 1, 1'b1);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, 100, -100, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_STOP, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_SET_TARGET, -100, 100, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_STANDBY, 0, 0, 1'b1);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_STANDBY, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       configure(1, 0, 1'b0, 1'b0, 8);
                1:       configure(255, 1, 1'b1, 1'b1, 14);
                2:       configure(0, 3, 1'b0, 1'b1, 15);
                3:       configure(3, 5, 1'b1, 1'b0, 0);
                4:       configure(7, 2, 1'b1, 1'b0, 1);
                default: configure($urandom_range(255), $urandom_range(30), $urandom_range(1),
                                   $urandom_range(1), $urandom_range(15));
            endcase
            if (ph < 3) begin
                send_idle_pct = 16;
                recv_idle_pct = 87;
            end else if (ph < 6) begin
                send_idle_pct = 87;
                recv_idle_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // let the pipeline run dry once mid-phase
                if (ph == 1 && i == PHASE_ITEMS / 2) drain();
                random_item();
            end
            drain();
        end

        // Counter runs past the interval in standby, then steps on the first tick out
        configure(255, 20, 1'b0, 1'b0, 14);
        send_cmd(FUNC_STANDBY, 0, 0, 1'b1);
        send_cmd(FUNC_SET_TARGET, 200, -200, 1'b0);
        for (int i = 0; i < STBY_TICK_RUN; i++) send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_STANDBY, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        send_cmd(FUNC_TICK, 0, 0, 1'b0);
        drain();
        repeat (10) @(posedge aclk);

        $display("Checked %0d bridge beats across %0d register writes and three idle patterns.",
                 book.beats_checked, book.reg_writes);
        $display("Ramp moves %0d, standby entries %0d, stops %0d, ticks at saturation %0d.",
                 book.ramp_moves, book.standby_entries, book.stops, book.sat_ticks);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: dual_motor_ramp_hbridge_drive.f
rtl/core/dmrhd_pkg.sv
rtl/core/dual_motor_ramp_hbridge_drive.sv
rtl/core/dmrhd_checker.sv
tb/dual_motor_ramp_hbridge_drive_tb.sv
